// ===== rtl/h2r_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_pkg
// Field widths and shared constants of the hsl to rgb converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int HUE_W   = 11;
    localparam int FRAC_W  = 8;
    localparam int CHAN_W  = 8;

    typedef logic [HUE_W-1:0]  hue_t;
    typedef logic [FRAC_W-1:0] frac_t;
    typedef logic [CHAN_W-1:0] chan_t;

endpackage

// ===== rtl/h2r_hsl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_hsl_if
// Valid/ready channel that carries one hsl pixel with alpha.
// ----------------------------------------------------------------------------
interface h2r_hsl_if
    import h2r_pkg::*;
;
    logic  valid;
    logic  ready;
    hue_t  hue;
    frac_t saturation;
    frac_t lightness;
    chan_t opacity;

    modport source (output valid, output hue, output saturation, output lightness,
                    output opacity, input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    input opacity, output ready);
endinterface

// ===== rtl/h2r_rgb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_rgb_if
// Valid/ready channel that carries one rgb pixel with alpha.
// ----------------------------------------------------------------------------
interface h2r_rgb_if
    import h2r_pkg::*;
;
    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t opacity_out;

    modport source (output valid, output red, output green, output blue,
                    output opacity_out, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input opacity_out, output ready);
endinterface

// ===== rtl/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Streaming hsl to rgb pixel converter, chroma and sector method.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while its output is taken and
// returns the results in order. Hue counts 1/256 of a 60 degree sector
// (0..1535 is one full turn; 1536..2047 keep the last sector's placement,
// x by sector parity), saturation and lightness are 8-bit fractions with
// 255 meaning 1.0, and alpha is copied through. Each channel is rounded
// once to the nearest 8-bit value. The six register stages are: chroma
// factor and hue weight, chroma product, x and offset products, channel
// placement with rounding bias, reciprocal estimate of the divide by 255,
// and correction plus clamp into the output register. Every stage has its
// own valid bit and holds on its own when the stage after it is full and
// held, so bubbles close up and the input stays ready while any stage is empty.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter
    import h2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    h2r_hsl_if.sink   hsl,
    h2r_rgb_if.source rgb
);

    localparam int NUM_ST = 6;

    // stage payloads
    typedef struct packed {
        logic [7:0] kfac;    // 255 - |2l - 255|
        logic [8:0] gwt;     // hue weight for x, 0..256
        logic [2:0] sector;
        frac_t      sat;
        frac_t      lit;
        chan_t      alpha;
    } st1_t;

    typedef struct packed {
        logic [15:0] cn;     // chroma, 65025 means 1.0
        logic [8:0]  gwt;
        logic [2:0]  sector;
        frac_t       lit;
        chan_t       alpha;
    } st2_t;

    typedef struct packed {
        logic [15:0] cn;
        logic [23:0] xv;
        logic [23:0] mv;
        logic [2:0]  sector;
        chan_t       alpha;
    } st3_t;

    typedef struct packed {
        logic [2:0][16:0] tq;   // (v + half) >> 8, still to divide by 255
        chan_t            alpha;
    } st4_t;

    typedef struct packed {
        logic [2:0][16:0] tq;
        logic [2:0][9:0]  q0;   // quotient estimate, low by at most one
        chan_t            alpha;
    } st5_t;

    typedef struct packed {
        logic [2:0][7:0] ch;    // red, green, blue
        chan_t           alpha;
    } st6_t;

    logic [NUM_ST:1]   valid_reg;
    logic [NUM_ST+1:1] en;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    st6_t s6_reg, s6_next;

    logic [2:0][16:0] rem;

    // a stage may load when it is empty or the stage after it moves on
    always_comb
    begin
        en[NUM_ST+1] = rgb.ready;
        for (int i = NUM_ST; i >= 1; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign hsl.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= hsl.valid;
            end
            for (int i = 2; i <= NUM_ST; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage 1: chroma factor and hue weight
    always_comb
    begin
        logic [8:0] twol;
        logic [8:0] ldev;
        twol = {hsl.lightness, 1'b0};
        ldev = (twol >= 9'd255) ? (twol - 9'd255) : (9'd255 - twol);
        s1_next.kfac   = 8'(9'd255 - ldev);
        s1_next.sector = hsl.hue[10:8];
        s1_next.gwt    = hsl.hue[8] ? (9'd256 - {1'b0, hsl.hue[7:0]})
                                    : {1'b0, hsl.hue[7:0]};
        s1_next.sat    = hsl.saturation;
        s1_next.lit    = hsl.lightness;
        s1_next.alpha  = hsl.opacity;
    end

    // stage 2: chroma product
    always_comb
    begin
        s2_next.cn     = 16'(s1_reg.kfac * s1_reg.sat);
        s2_next.gwt    = s1_reg.gwt;
        s2_next.sector = s1_reg.sector;
        s2_next.lit    = s1_reg.lit;
        s2_next.alpha  = s1_reg.alpha;
    end

    // stage 3: x = cn * g, m = l * 65280 - cn * 128 (never negative)
    always_comb
    begin
        logic [24:0] xfull;
        xfull          = 25'(s2_reg.cn * s2_reg.gwt);
        s3_next.cn     = s2_reg.cn;
        s3_next.xv     = xfull[23:0];
        s3_next.mv     = {s2_reg.lit, 16'd0} - {8'd0, s2_reg.lit, 8'd0}
                         - {1'b0, s2_reg.cn, 7'd0};
        s3_next.sector = s2_reg.sector;
        s3_next.alpha  = s2_reg.alpha;
    end

    // stage 4: sector placement, offset and rounding bias, drop the low byte
    always_comb
    begin
        logic [23:0]      cv;
        logic [2:0][23:0] pv;
        logic [25:0]      sum;
        cv = {s3_reg.cn, 8'd0};
        case (s3_reg.sector)
            3'd0:    pv = {24'd0, s3_reg.xv, cv};
            3'd1:    pv = {24'd0, cv, s3_reg.xv};
            3'd2:    pv = {s3_reg.xv, cv, 24'd0};
            3'd3:    pv = {cv, s3_reg.xv, 24'd0};
            3'd4:    pv = {cv, 24'd0, s3_reg.xv};
            default: pv = {s3_reg.xv, 24'd0, cv};
        endcase
        for (int i = 0; i < 3; i++)
        begin
            sum           = 26'(pv[i]) + 26'(s3_reg.mv) + 26'd32640;
            s4_next.tq[i] = sum[24:8];
        end
        s4_next.alpha = s3_reg.alpha;
    end

    // stage 5: t / 255 estimated as (t * 257) >> 16
    always_comb
    begin
        logic [25:0] prod;
        for (int i = 0; i < 3; i++)
        begin
            prod          = {1'b0, s4_reg.tq[i], 8'd0} + 26'(s4_reg.tq[i]);
            s5_next.q0[i] = prod[25:16];
        end
        s5_next.tq    = s4_reg.tq;
        s5_next.alpha = s4_reg.alpha;
    end

    // stage 6: one correction step, then clamp to 255
    always_comb
    begin
        logic [17:0] q255;
        logic [9:0]  q;
        for (int i = 0; i < 3; i++)
        begin
            q255   = {s5_reg.q0[i], 8'd0} - 18'(s5_reg.q0[i]);
            rem[i] = 17'(18'(s5_reg.tq[i]) - q255);
            q      = (rem[i] >= 17'd255) ? (s5_reg.q0[i] + 10'd1) : s5_reg.q0[i];
            s6_next.ch[i] = (q > 10'd255) ? 8'd255 : q[7:0];
        end
        s6_next.alpha = s5_reg.alpha;
    end

    // payload registers follow their stage enables
    always_ff @(posedge clk)
    begin
        if (en[1]) s1_reg <= s1_next;
        if (en[2]) s2_reg <= s2_next;
        if (en[3]) s3_reg <= s3_next;
        if (en[4]) s4_reg <= s4_next;
        if (en[5]) s5_reg <= s5_next;
        if (en[6]) s6_reg <= s6_next;
    end

    assign rgb.valid       = valid_reg[NUM_ST];
    assign rgb.red         = s6_reg.ch[0];
    assign rgb.green       = s6_reg.ch[1];
    assign rgb.blue        = s6_reg.ch[2];
    assign rgb.opacity_out = s6_reg.alpha;

`ifndef SYNTHESIS
    // input backpressure only when every stage holds an item
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !hsl.ready |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    // reciprocal estimate is never more than one low
    a_quot_estimate: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> (rem[0] < 17'd510 && rem[1] < 17'd510 && rem[2] < 17'd510))
        else $error("divide by 255 estimate out of range");

    // a held middle stage keeps its item
    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] && !en[4] |=> valid_reg[3] && $stable(s3_reg))
        else $error("stage 3 item lost during stall");

    // output drains when nothing follows
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        rgb.valid && rgb.ready && !valid_reg[5] |=> !rgb.valid)
        else $error("output item repeated");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hsl to rgb pixel converter.
// ----------------------------------------------------------------------------
// Pixels go in on the hsl channel and each one is converted on the side by an
// exact integer version of the chroma and sector method. Every result that
// leaves on the rgb channel is compared field by field, in order, with the
// oldest prediction. Both sides idle and stall at random, with full-rate
// stretches and a pause in which the sender waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module testbench
    import h2r_pkg::*;
;

    // fixed-point scale of the conversion
    localparam int unsigned FRAC_ONE  = 255;
    localparam int unsigned HUE_STEPS = 256;
    localparam int unsigned CH_DIV    = 65280;   // 255 * 256
    localparam int unsigned CH_HALF   = 32640;   // rounding bias, half of CH_DIV
    localparam int unsigned CHAN_MAX  = 255;

    // hue sectors, sixty degrees each; the last two lie past a full turn
    localparam int unsigned SEC_RED_YELLOW    = 0;
    localparam int unsigned SEC_YELLOW_GREEN  = 1;
    localparam int unsigned SEC_GREEN_CYAN    = 2;
    localparam int unsigned SEC_CYAN_BLUE     = 3;
    localparam int unsigned SEC_BLUE_MAGENTA  = 4;
    localparam int unsigned SEC_MAGENTA_RED   = 5;
    localparam int unsigned SEC_PAST_TURN     = 6;
    localparam int unsigned SEC_PAST_TURN_TOP = 7;

    localparam int unsigned HUE_TURN_MAX = 1535;
    localparam int unsigned HUE_FIELD_MAX = 2047;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t opacity_out;
    } rgb_pixel_t;

    logic clk;
    logic rst_n;

    h2r_hsl_if hsl_ch ();
    h2r_rgb_if rgb_ch ();

    hsl_to_rgb_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsl   (hsl_ch.sink),
        .rgb   (rgb_ch.source)
    );

    rgb_pixel_t rgb_expected_q[$];
    rgb_pixel_t rgb_want;
    int unsigned mismatch_count = 0;
    bit steady_flow = 1'b0;   // when set neither side idles

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // round half up from 1/(65025*256) units to 8 bits, clamp as a guard
    function automatic chan_t round_to_chan(int unsigned acc);
        int unsigned q;
        q = (acc + CH_HALF) / CH_DIV;
        return (q > CHAN_MAX) ? chan_t'(CHAN_MAX) : chan_t'(q);
    endfunction

    // chroma and sector conversion of one pixel in exact integer arithmetic
    function automatic rgb_pixel_t convert_hsl(hue_t hue, frac_t sat, frac_t lit,
                                               chan_t alpha);
        int unsigned sector, frac, twice_l, spread, chroma, weight;
        int unsigned c_full, x_part, offset, r_acc, g_acc, b_acc;
        rgb_pixel_t px;
        sector  = hue[10:8];
        frac    = hue[7:0];
        twice_l = 2 * int'(lit);
        spread  = (twice_l >= FRAC_ONE) ? twice_l - FRAC_ONE : FRAC_ONE - twice_l;
        chroma  = (FRAC_ONE - spread) * int'(sat);
        // x rises through even sectors and falls through odd ones
        weight  = sector[0] ? HUE_STEPS - frac : frac;
        c_full  = chroma * HUE_STEPS;
        x_part  = chroma * weight;
        offset  = int'(lit) * CH_DIV - chroma * 128;
        r_acc = 0;
        g_acc = 0;
        b_acc = 0;
        case (sector)
            SEC_RED_YELLOW:
            begin
                r_acc = c_full;
                g_acc = x_part;
            end
            SEC_YELLOW_GREEN:
            begin
                r_acc = x_part;
                g_acc = c_full;
            end
            SEC_GREEN_CYAN:
            begin
                g_acc = c_full;
                b_acc = x_part;
            end
            SEC_CYAN_BLUE:
            begin
                g_acc = x_part;
                b_acc = c_full;
            end
            SEC_BLUE_MAGENTA:
            begin
                r_acc = x_part;
                b_acc = c_full;
            end
            default:
            begin
                // magenta-red, and hues past a full turn placed the same way
                r_acc = c_full;
                b_acc = x_part;
            end
        endcase
        px.red         = round_to_chan(r_acc + offset);
        px.green       = round_to_chan(g_acc + offset);
        px.blue        = round_to_chan(b_acc + offset);
        px.opacity_out = alpha;
        return px;
    endfunction

    // hue from sector and fraction
    function automatic hue_t hue_at(int unsigned sector, int unsigned frac);
        return hue_t'(sector * HUE_STEPS + frac);
    endfunction

    // present one pixel, hold it until taken, then log its prediction;
    // called just after a rising edge, returns just after the accepting edge
    task automatic send_pixel(hue_t hue, frac_t sat, frac_t lit, chan_t alpha);
        int unsigned gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            hsl_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsl_ch.valid      <= 1'b1;
        hsl_ch.hue        <= hue;
        hsl_ch.saturation <= sat;
        hsl_ch.lightness  <= lit;
        hsl_ch.opacity    <= alpha;
        @(posedge clk);
        while (!hsl_ch.ready)
            @(posedge clk);
        rgb_expected_q = {rgb_expected_q, convert_hsl(hue, sat, lit, alpha)};
    endtask

    // sender goes quiet until every predicted pixel is back
    task automatic wait_drained();
        hsl_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (rgb_expected_q.size() != 0);
    endtask

    // saturation or lightness biased toward the ends and the midpoint
    function automatic frac_t pick_frac();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd127;
            3: return 8'd128;
            default: return frac_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic hue_t pick_hue();
        if ($urandom_range(0, 99) < 85)
            return hue_t'($urandom_range(0, HUE_TURN_MAX));
        return hue_t'($urandom_range(0, HUE_FIELD_MAX));
    endfunction

    task automatic send_random_pixel();
        send_pixel(pick_hue(), pick_frac(), pick_frac(), chan_t'($urandom_range(0, 255)));
    endtask

    // start and end of every sector, hues past a full turn, grey, black, white
    task automatic test_sector_edges();
        send_pixel(hue_at(SEC_RED_YELLOW, 0), 8'd255, 8'd128, 8'd255);
        send_pixel(hue_at(SEC_RED_YELLOW, 255), 8'd255, 8'd127, 8'd0);
        send_pixel(hue_at(SEC_YELLOW_GREEN, 0), 8'd255, 8'd128, 8'd170);
        send_pixel(hue_at(SEC_YELLOW_GREEN, 255), 8'd200, 8'd100, 8'd85);
        send_pixel(hue_at(SEC_GREEN_CYAN, 0), 8'd255, 8'd128, 8'd1);
        send_pixel(hue_at(SEC_GREEN_CYAN, 255), 8'd128, 8'd64, 8'd254);
        send_pixel(hue_at(SEC_CYAN_BLUE, 0), 8'd255, 8'd127, 8'd128);
        send_pixel(hue_at(SEC_CYAN_BLUE, 255), 8'd255, 8'd192, 8'd127);
        send_pixel(hue_at(SEC_BLUE_MAGENTA, 0), 8'd255, 8'd128, 8'd255);
        send_pixel(hue_at(SEC_BLUE_MAGENTA, 255), 8'd1, 8'd1, 8'd0);
        send_pixel(hue_at(SEC_MAGENTA_RED, 0), 8'd255, 8'd128, 8'd15);
        send_pixel(hue_at(SEC_MAGENTA_RED, 255), 8'd255, 8'd254, 8'd240);
        // fraction at the middle of a sector
        send_pixel(hue_at(SEC_RED_YELLOW, 128), 8'd255, 8'd128, 8'd90);
        send_pixel(hue_at(SEC_YELLOW_GREEN, 128), 8'd255, 8'd128, 8'd165);
        // hues past a full turn keep the last placement, x by sector parity
        send_pixel(hue_at(SEC_PAST_TURN, 0), 8'd255, 8'd128, 8'd255);
        send_pixel(hue_at(SEC_PAST_TURN, 128), 8'd255, 8'd128, 8'd0);
        send_pixel(hue_at(SEC_PAST_TURN_TOP, 0), 8'd255, 8'd128, 8'd77);
        send_pixel(hue_at(SEC_PAST_TURN_TOP, 255), 8'd255, 8'd255, 8'd0);
        // no saturation gives grey, lightness ends give black and white
        send_pixel(hue_at(SEC_GREEN_CYAN, 77), 8'd0, 8'd200, 8'd33);
        send_pixel(hue_at(SEC_CYAN_BLUE, 200), 8'd255, 8'd0, 8'd255);
        send_pixel(hue_at(SEC_BLUE_MAGENTA, 50), 8'd255, 8'd255, 8'd0);
        send_pixel(hue_t'(0), 8'd0, 8'd0, 8'd0);
    endtask

    // neither side idles, one pixel per clock
    task automatic test_full_rate();
        steady_flow = 1'b1;
        repeat (40) send_random_pixel();
        steady_flow = 1'b0;
    endtask

    // bursts with the sender holding off until the pipeline has emptied
    task automatic test_drain_pause();
        repeat (4)
        begin
            repeat (20) send_random_pixel();
            wait_drained();
        end
    endtask

    // long random stream with idling on both sides
    task automatic test_random_stream();
        repeat (1000) send_random_pixel();
    endtask

    // receiver: ready with random stalls, always high in a full-rate stretch
    initial
    begin : sink_stall
        int unsigned hold;
        hold = 0;
        rgb_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (steady_flow || hold == 0)
            begin
                rgb_ch.ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
            else
            begin
                rgb_ch.ready <= 1'b0;
                hold = hold - 1;
            end
        end
    end

    task automatic report_field(string field, chan_t want, chan_t got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // result side: each taken pixel against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
        begin
            if (rgb_expected_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: pixel expected none actual r%0d g%0d b%0d a%0d", $time,
                         rgb_ch.red, rgb_ch.green, rgb_ch.blue, rgb_ch.opacity_out);
            end
            else
            begin
                rgb_want = rgb_expected_q.pop_front();
                report_field("red", rgb_want.red, rgb_ch.red);
                report_field("green", rgb_want.green, rgb_ch.green);
                report_field("blue", rgb_want.blue, rgb_ch.blue);
                report_field("opacity_out", rgb_want.opacity_out, rgb_ch.opacity_out);
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n                <= 1'b0;
        hsl_ch.valid         <= 1'b0;
        hsl_ch.hue           <= '0;
        hsl_ch.saturation    <= '0;
        hsl_ch.lightness     <= '0;
        hsl_ch.opacity       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sector_edges();
        test_full_rate();
        test_drain_pause();
        test_random_stream();

        hsl_ch.valid <= 1'b0;
        while (rgb_expected_q.size() != 0)
            @(posedge clk);
        // anything extra would show up within the pipeline depth
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("hsl_to_rgb_converter: match");
        else
            $display("hsl_to_rgb_converter: mismatch");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial
    begin
        #5ms;
        $display("hsl_to_rgb_converter: mismatch");
        $finish;
    end

endmodule

// ===== hsl_to_rgb_converter.f =====
rtl/h2r_pkg.sv
rtl/h2r_hsl_if.sv
rtl/h2r_rgb_if.sv
rtl/hsl_to_rgb_converter.sv
tb/testbench.sv
